FILE: design/wrap_aware_moving_average_defines.svh
`ifndef WRAP_AWARE_MOVING_AVERAGE_DEFINES_SVH
`define WRAP_AWARE_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define WAM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define WAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/wam_pkg.sv
`timescale 1ns / 1ps

package wam_pkg;

  // Fixed widths of the ports.
  localparam int SAMPLE_W = 16;
  localparam int CFG_DATA_W = 17;
  localparam int WIN_FIELD_W = 7;
  localparam int REV_FIELD_W = 17;
  localparam int REG_IDX_W = 1;

  // Register indexes of the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_REV_COUNTS = 1'b1;

  // Values after reset, and the window taken when zero is requested.
  localparam int DEFAULT_WINDOW = 8;
  localparam int DEFAULT_REV = 4096;

  // Status of the serial divider as seen by the control logic.
  typedef struct packed {
    logic busy;
    logic done;
  } wam_div_status_t;

endpackage

FILE: design/wam_div.sv
`timescale 1ns / 1ps

module wam_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [NUM_W-1:0]       numer,
  input  logic        [DEN_W-1:0]       denom,
  output wam_pkg::wam_div_status_t      status,
  output logic signed [NUM_W-1:0]       quot
);
  import wam_pkg::*;

  localparam int MAG_W = NUM_W - 1;
  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic             done;
  logic             neg;
  logic [MAG_W-1:0] dq;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_diff;
  logic             qbit;

  // Floor division of a negative numerator N is taken as the complement of
  // floor(~N / D), so the iteration itself only ever sees a non-negative value.
  assign trial      = {rem, dq[MAG_W-1]};
  assign trial_diff = trial - {1'b0, dvs};
  assign qbit       = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= numer[NUM_W-1];
      dq  <= numer[NUM_W-1] ? ~numer[MAG_W-1:0] : numer[MAG_W-1:0];
      rem <= '0;
      dvs <= denom;
    end else if (busy) begin
      if (qbit) begin
        rem <= trial_diff[DEN_W-1:0];
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      dq <= {dq[MAG_W-2:0], qbit};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quot = neg ? $signed(~{1'b0, dq}) : $signed({1'b0, dq});

endmodule

FILE: design/wrap_aware_moving_average.sv
`timescale 1ns / 1ps

// Channel   | Valid          | Stall          | Payload
// ----------+----------------+----------------+--------------------------------
// input     | sample_valid   | sample_stall   | sample
// output    | average_valid  | average_stall  | average
// config    | write_enable   | (none)         | reg_index, write_data
//
// With a window of one an item goes from acceptance straight to S_OUT and the output register.
// Otherwise it passes S_PREP, S_UPD, S_DIV and S_FIX, with the bit-serial divider in
// S_DIV giving one quotient bit a cycle.
// Reset and every configuration write start a clearing pass over the whole ring
// memory, writing zero to every entry; no sample is taken during it.
// One item is in flight at a time; the output register holds a finished result
// under average_stall while the next sample is already being accepted.

module wrap_aware_moving_average #(
  parameter int MAX_WINDOW = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic [wam_pkg::SAMPLE_W-1:0]       sample,
  output logic                               average_valid,
  input  logic                               average_stall,
  output logic [wam_pkg::SAMPLE_W-1:0]       average,
  input  logic                               write_enable,
  input  logic [wam_pkg::REG_IDX_W-1:0]      reg_index,
  input  logic [wam_pkg::CFG_DATA_W-1:0]     write_data
);
  import wam_pkg::*;

  localparam int REV_W   = ((COUNT_BITS > 12) ? COUNT_BITS : 12) + 1;
  localparam int ENTRY_W = REV_W + 3;
  localparam int PTR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = ENTRY_W + $clog2(MAX_WINDOW) + 1;
  localparam int NUM_W   = SUM_W + 1;
  localparam int DEN_W   = WIN_W + 1;
  localparam int PROD_W  = REV_W + WIN_W;
  localparam int SAT_W   = (SAMPLE_W > REV_W) ? SAMPLE_W : REV_W;
  localparam int WIN_RESET = (DEFAULT_WINDOW > MAX_WINDOW) ? MAX_WINDOW : DEFAULT_WINDOW;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_PREP  = 7'b0000100,
    S_UPD   = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_FIX   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  // Configuration and values derived from it.
  logic [WIN_W-1:0]        window;
  logic [REV_W-1:0]        rev;
  logic [REV_W-1:0]        thr;
  logic [PROD_W-1:0]       rev_w;
  logic [REV_W+1:0]        rev3;
  logic [WIN_FIELD_W-1:0]  win_req;
  logic [WIN_W-1:0]        win_cfg;
  logic [REV_FIELD_W-1:0]  rev_req;
  logic [REV_W-1:0]        rev_cfg;

  // Filter state. Ring entries are kept relative to a common offset, so a
  // shift of the whole ring by one revolution is a single add to the offset.
  logic [ENTRY_W-1:0]        ring [MAX_WINDOW];
  logic [ENTRY_W-1:0]        rd_data;
  logic [PTR_W-1:0]          ptr;
  logic [PTR_W-1:0]          clr_addr;
  logic signed [SUM_W-1:0]   sum;
  logic signed [ENTRY_W-1:0] last_avg;
  logic [ENTRY_W-1:0]        offset;

  // Per-item working registers.
  logic [SAMPLE_W-1:0]       raw;
  logic signed [ENTRY_W-1:0] s_adj;
  logic signed [NUM_W-1:0]   avg;
  logic [SAMPLE_W-1:0]       result;

  // Datapath terms.
  logic [SAT_W-1:0]          raw_x;
  logic [SAT_W-1:0]          rev_m1_x;
  logic [SAT_W-1:0]          s_sat;
  logic signed [ENTRY_W-1:0] s_val;
  logic signed [ENTRY_W-1:0] rev_e;
  logic signed [ENTRY_W:0]   delta;
  logic [ENTRY_W:0]          mag;
  logic                      wrap;
  logic signed [ENTRY_W-1:0] s_wrapped;
  logic signed [ENTRY_W-1:0] old_val;
  logic signed [SUM_W-1:0]   sum_upd;
  logic signed [NUM_W-1:0]   numer;
  logic [DEN_W-1:0]          denom;
  logic signed [NUM_W-1:0]   rev_n;
  logic signed [SUM_W-1:0]   rev_w_s;
  logic                      avg_lo;
  logic                      avg_hi;
  logic signed [NUM_W-1:0]   avg_fixed;
  logic [PTR_W-1:0]          ptr_next;

  logic                      mem_we;
  logic [PTR_W-1:0]          mem_waddr;
  logic [ENTRY_W-1:0]        mem_wdata;

  logic                      sample_take;
  logic                      out_load;
  logic                      div_start;
  wam_div_status_t           div_status;
  logic signed [NUM_W-1:0]   div_quot;

  assign sample_stall = (state != S_IDLE);
  assign sample_take  = sample_valid && !sample_stall;
  assign out_load     = (state == S_OUT) && (!average_valid || !average_stall);

  // Configuration decode: zero window means the default, and both registers
  // saturate into their legal ranges.
  always_comb begin
    win_req = (write_data[WIN_FIELD_W-1:0] == '0) ? WIN_FIELD_W'(DEFAULT_WINDOW)
                                                   : write_data[WIN_FIELD_W-1:0];
    if (32'(win_req) > MAX_WINDOW) begin
      win_cfg = WIN_W'(MAX_WINDOW);
    end else begin
      win_cfg = WIN_W'(win_req);
    end
    rev_req = write_data[REV_FIELD_W-1:0];
    if (rev_req < REV_FIELD_W'(2)) begin
      rev_cfg = REV_W'(2);
    end else if (32'(rev_req) > (32'd1 << COUNT_BITS)) begin
      rev_cfg = REV_W'(32'd1 << COUNT_BITS);
    end else begin
      rev_cfg = REV_W'(rev_req);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WIN_W'(WIN_RESET);
      rev    <= REV_W'(DEFAULT_REV);
    end else if (write_enable) begin
      unique case (reg_index)
        REG_WINDOW_LEN: window <= win_cfg;
        REG_REV_COUNTS: rev    <= rev_cfg;
      endcase
    end
  end

  // Derived constants, registered; configuration is stable long before use.
  assign rev3 = {2'b00, rev} + {1'b0, rev, 1'b0};

  always_ff @(posedge clk) begin
    thr   <= rev3[REV_W+1:2];
    rev_w <= PROD_W'(rev) * PROD_W'(window);
  end

  // Sample conditioning and wrap detection against the previous average.
  always_comb begin
    raw_x    = SAT_W'(raw);
    rev_m1_x = SAT_W'(rev) - 1'b1;
    s_sat    = (raw_x > rev_m1_x) ? rev_m1_x : raw_x;
    s_val    = $signed({3'b000, s_sat[REV_W-1:0]});
    rev_e    = $signed(ENTRY_W'(rev));
    delta    = (ENTRY_W+1)'(s_val) - (ENTRY_W+1)'(last_avg);
    mag      = delta[ENTRY_W] ? (ENTRY_W+1)'(-delta) : delta;
    wrap     = (mag >= (ENTRY_W+1)'(thr));
    if (!wrap) begin
      s_wrapped = s_val;
    end else if (delta[ENTRY_W]) begin
      s_wrapped = s_val + rev_e;
    end else begin
      s_wrapped = s_val - rev_e;
    end
  end

  // Ring update and the numerator of the rounded average 2*sum + w over 2*w.
  always_comb begin
    old_val = $signed(rd_data + offset);
    sum_upd = sum - SUM_W'(old_val) + SUM_W'(s_adj);
    numer   = $signed({sum_upd, 1'b0}) + $signed(NUM_W'(window));
    denom   = {window, 1'b0};
    ptr_next = (ptr == PTR_W'(window - 1'b1)) ? '0 : ptr + 1'b1;
  end

  // Range correction of the fresh average.
  always_comb begin
    rev_n   = $signed(NUM_W'(rev));
    rev_w_s = $signed(SUM_W'(rev_w));
    avg_lo  = avg[NUM_W-1];
    avg_hi  = (avg >= rev_n);
    priority if (avg_lo) begin
      avg_fixed = avg + rev_n;
    end else if (avg_hi) begin
      avg_fixed = avg - rev_n;
    end else begin
      avg_fixed = avg;
    end
  end

  assign div_start = (state == S_UPD);

  wam_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .numer  (numer),
    .denom  (denom),
    .status (div_status),
    .quot   (div_quot)
  );

  // Ring memory: one write port, one registered read port at the pointer.
  always_comb begin
    mem_we    = (state == S_CLEAR) || (state == S_UPD);
    mem_waddr = (state == S_CLEAR) ? clr_addr : ptr;
    mem_wdata = (state == S_CLEAR) ? '0 : ENTRY_W'(s_adj) - offset;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[mem_waddr] <= mem_wdata;
    end
    rd_data <= ring[ptr];
  end

  // Control and filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      ptr      <= '0;
      sum      <= '0;
      last_avg <= '0;
      offset   <= '0;
    end else if (write_enable) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      ptr      <= '0;
      sum      <= '0;
      last_avg <= '0;
      offset   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == PTR_W'(MAX_WINDOW - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (sample_take) begin
            if (window == WIN_W'(1)) begin
              state <= S_OUT;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          sum   <= sum_upd;
          ptr   <= ptr_next;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_status.done && !div_status.busy) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          priority if (avg_lo) begin
            sum    <= sum + rev_w_s;
            offset <= offset + ENTRY_W'(rev);
          end else if (avg_hi) begin
            sum    <= sum - rev_w_s;
            offset <= offset - ENTRY_W'(rev);
          end
          last_avg <= ENTRY_W'(avg_fixed);
          state    <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // Per-item payload registers.
  always_ff @(posedge clk) begin
    if (sample_take) begin
      raw    <= sample;
      result <= sample;
    end
    if (state == S_PREP) begin
      s_adj <= s_wrapped;
    end
    if ((state == S_DIV) && div_status.done) begin
      avg <= div_quot;
    end
    if (state == S_FIX) begin
      result <= avg_fixed[SAMPLE_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      average_valid <= 1'b0;
    end else if (out_load) begin
      average_valid <= 1'b1;
    end else if (!average_stall) begin
      average_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      average <= result;
    end
  end

endmodule

FILE: design/wam_checker.sv
`timescale 1ns / 1ps

`include "wrap_aware_moving_average_defines.svh"

module wam_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               sample_valid,
  input logic                               sample_stall,
  input logic                               average_valid,
  input logic                               average_stall,
  input logic [wam_pkg::SAMPLE_W-1:0]       average,
  input logic                               write_enable
);

  // A result held under stall keeps its value.
  `WAM_ASSERT_NEXT(a_out_hold, average_valid && average_stall, average_valid && $stable(average), "average changed while stalled")

  // Only one sample is worked on at a time.
  `WAM_ASSERT_NEXT(a_one_in_flight, sample_valid && !sample_stall, sample_stall, "second sample taken while busy")

  // A configuration write starts the clearing pass, which blocks samples.
  `WAM_ASSERT_NEXT(a_cfg_clears, write_enable, sample_stall, "sample taken right after a configuration write")

  // A fresh result in the output register comes with the input free again.
  `WAM_ASSERT_NOW(a_result_frees_input, $rose(average_valid), !sample_stall, "input still blocked after a result")

endmodule

bind wrap_aware_moving_average wam_checker u_wam_checker (.*);

FILE: sim/wam_average_checker.sv
`timescale 1ns / 1ps

module wam_average_checker #(
  parameter int MAX_WINDOW = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  input  logic                          sample_stall,
  input  logic [wam_pkg::SAMPLE_W-1:0]  sample,
  input  logic                          average_valid,
  input  logic                          average_stall,
  input  logic [wam_pkg::SAMPLE_W-1:0]  average,
  input  logic                          write_enable,
  input  logic [wam_pkg::REG_IDX_W-1:0] reg_index,
  input  logic [wam_pkg::CFG_DATA_W-1:0] write_data,
  output int                            fail_count,
  output int                            pending
);
  import wam_pkg::*;

  // Shadow copy of the filter state, kept in wide signed arithmetic.
  longint      ring [MAX_WINDOW];
  int unsigned wr_ptr;
  longint      acc_sum;
  longint      prev_avg;
  int unsigned win_len;
  longint      rev;

  logic [SAMPLE_W-1:0] avg_expected [$];
  int                  mismatches;

  initial begin
    fail_count = 0;
    pending = 0;
    mismatches = 0;
  end

  function automatic void clear_window();
    for (int i = 0; i < MAX_WINDOW; i++) ring[i] = 0;
    wr_ptr = 0;
    acc_sum = 0;
    prev_avg = 0;
  endfunction

  function automatic void apply_write(logic [REG_IDX_W-1:0] idx,
                                      logic [CFG_DATA_W-1:0] data);
    longint val;
    case (idx)
      REG_WINDOW_LEN: begin
        val = data[WIN_FIELD_W-1:0];
        if (val == 0) val = DEFAULT_WINDOW;
        if (val > MAX_WINDOW) val = MAX_WINDOW;
        win_len = 32'(val);
      end
      REG_REV_COUNTS: begin
        val = data[REV_FIELD_W-1:0];
        if (val < 2) val = 2;
        if (val > (longint'(1) << COUNT_BITS)) val = longint'(1) << COUNT_BITS;
        rev = val;
      end
    endcase
    clear_window();
  endfunction

  function automatic logic [SAMPLE_W-1:0] predict_average(logic [SAMPLE_W-1:0] raw);
    longint s;
    longint w;
    longint delta;
    longint mag;
    longint num;
    longint den;
    longint q;
    longint adj;
    if (win_len <= 1) return raw;
    w = win_len;
    s = raw;
    if (s > rev - 1) s = rev - 1;
    // A jump of three quarters of a revolution or more is taken as a wrap.
    delta = s - prev_avg;
    mag = (delta < 0) ? -delta : delta;
    if (mag >= (3 * rev) / 4) s = (delta < 0) ? s + rev : s - rev;
    if (wr_ptr >= win_len) wr_ptr = 0;
    acc_sum = acc_sum - ring[wr_ptr] + s;
    ring[wr_ptr] = s;
    wr_ptr = (wr_ptr + 1) % win_len;
    // Rounded half up, with a floor that holds for negative sums.
    num = 2 * acc_sum + w;
    den = 2 * w;
    q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    if (q > rev - 1 || q < 0) begin
      adj = (q < 0) ? rev : -rev;
      acc_sum += adj * w;
      for (int i = 0; i < win_len; i++) ring[i] += adj;
      q += adj;
    end
    prev_avg = q;
    return q[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (rst) begin
      win_len = DEFAULT_WINDOW;
      rev = DEFAULT_REV;
      clear_window();
      avg_expected.delete();
    end else begin
      if (write_enable) apply_write(reg_index, write_data);
      if (sample_valid && !sample_stall) avg_expected.push_back(predict_average(sample));
      if (average_valid && !average_stall) begin
        if (avg_expected.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: average %0d arrived with no sample outstanding", $realtime,
                     average);
          mismatches++;
        end else begin
          want = avg_expected.pop_front();
          if (want !== average) begin
            if (mismatches < 10)
              $display("%0t: average expected %0d, got %0d", $realtime, want, average);
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    pending <= avg_expected.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import wam_pkg::*;

  localparam int MAX_WINDOW = 64;
  localparam int COUNT_BITS = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1850;
  localparam int N_SETS = 15;
  localparam int SETTLE_CYCLES = 48;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  logic [SAMPLE_W-1:0]   sample = '0;
  logic                  average_valid;
  logic                  average_stall = 1'b0;
  logic [SAMPLE_W-1:0]   average;
  logic                  write_enable = 1'b0;
  logic [REG_IDX_W-1:0]  reg_index = REG_WINDOW_LEN;
  logic [CFG_DATA_W-1:0] write_data = '0;

  int fail_count;
  int pending;
  int send_gap_pct = 8;
  int stall_pct = 79;
  int cycle_count = 0;

  // Encoder position that the random walk follows, and its revolution.
  longint enc_pos = 0;
  longint enc_rev = DEFAULT_REV;

  int win_tab [12] = '{2, 64, 1, 8, 3, 127, 33, 64, 2, 17, 5, 40};
  int rev_tab [12] = '{4096, 65536, 360, 2, 3, 131071, 1000, 7, 65536, 5, 0, 4096};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wrap_aware_moving_average #(
    .MAX_WINDOW(MAX_WINDOW),
    .COUNT_BITS(COUNT_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .average_valid(average_valid),
    .average_stall(average_stall),
    .average(average),
    .write_enable(write_enable),
    .reg_index(reg_index),
    .write_data(write_data)
  );

  wam_average_checker #(
    .MAX_WINDOW(MAX_WINDOW),
    .COUNT_BITS(COUNT_BITS)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .average_valid(average_valid),
    .average_stall(average_stall),
    .average(average),
    .write_enable(write_enable),
    .reg_index(reg_index),
    .write_data(write_data),
    .fail_count(fail_count),
    .pending(pending)
  );

  always @(posedge clk) begin
    average_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: errors");
    $finish;
  end

  // Returns in the time step of the edge that took the transaction.
  task automatic push_sample(input logic [SAMPLE_W-1:0] value);
    while ($urandom_range(99) < send_gap_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= value;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic configure(input int win, input int rev);
    write_reg(REG_WINDOW_LEN, win);
    write_reg(REG_REV_COUNTS, rev);
    enc_rev = rev[CFG_DATA_W-1:0];
    if (enc_rev < 2) enc_rev = 2;
    if (enc_rev > (longint'(1) << COUNT_BITS)) enc_rev = longint'(1) << COUNT_BITS;
    enc_pos = $urandom_range(enc_rev - 1);
  endtask

  // Mostly a plausible encoder walk that crosses the wrap now and then, with
  // some wild values and values at the top of the revolution mixed in.
  function automatic logic [SAMPLE_W-1:0] next_position();
    int     roll;
    longint step;
    longint pick;
    roll = $urandom_range(99);
    if (roll < 80) begin
      step = $urandom_range(enc_rev / 8 + 1);
      if ($urandom_range(1)) step = -step;
      if (roll < 15) step += $urandom_range(enc_rev - 1);
      enc_pos = ((enc_pos + step) % enc_rev + enc_rev) % enc_rev;
      return enc_pos[SAMPLE_W-1:0];
    end
    if (roll < 90) return $urandom_range(65535);
    case ($urandom_range(3))
      0: pick = enc_rev - 1;
      1: pick = (enc_rev > 65535) ? 65535 : enc_rev;
      2: pick = 65535;
      default: pick = 0;
    endcase
    return pick[SAMPLE_W-1:0];
  endfunction

  initial begin
    int win;
    int rev;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Defaults after reset: wraps both ways and a sample above the revolution.
    push_sample(16'd0);
    push_sample(16'd4095);
    push_sample(16'd65535);
    push_sample(16'd1);
    push_sample(16'd4000);
    push_sample(16'd100);
    push_sample(16'd2048);
    push_sample(16'd3072);
    // A zero window request falls back to the default window.
    configure(0, 4096);
    push_sample(16'd4095);
    push_sample(16'd0);
    // A window of one passes every sample straight through.
    configure(1, 4096);
    push_sample(16'd65535);
    push_sample(16'd0);
    push_sample(16'd4097);
    // Oversized window and a revolution below the minimum.
    configure(100, 1);
    push_sample(16'd1);
    push_sample(16'd0);
    push_sample(16'd65535);
    // Revolution above the top saturates to the full count range.
    configure(2, 131071);
    push_sample(16'd65535);
    push_sample(16'd0);
    push_sample(16'd32768);
    push_sample(16'd49152);
    configure(64, 65536);
    push_sample(16'd0);
    push_sample(16'd65535);
    push_sample(16'd40000);

    for (int k = 0; k < N_SETS; k++) begin
      if (k < N_SETS / 3) begin
        send_gap_pct = 8;
        stall_pct = 79;
      end else if (k < 2 * N_SETS / 3) begin
        send_gap_pct = 79;
        stall_pct = 8;
      end else begin
        send_gap_pct = 0;
        stall_pct = 0;
      end
      if (k < 12) begin
        win = win_tab[k];
        rev = rev_tab[k];
      end else begin
        win = $urandom_range(127);
        rev = $urandom_range(1) ? $urandom_range(64, 2) : $urandom_range(131071);
      end
      configure(win, rev);
      repeat (RANDOM_ITEMS / N_SETS) push_sample(next_position());
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/wam_pkg.sv
design/wam_div.sv
design/wrap_aware_moving_average.sv
design/wam_checker.sv
sim/wam_average_checker.sv
sim/tb.sv
